[design/wlp_pkg.sv]
`default_nettype none

package wlp_pkg;

    localparam int TIME_WIDTH = 32;
    localparam logic [31:0] TIME_MASK = (TIME_WIDTH >= 32) ? 32'hFFFF_FFFF
                                        : 32'((64'd1 << TIME_WIDTH) - 64'd1);

    localparam int CYC_W   = 32;
    localparam int LAT_W   = 16;
    localparam int STAMP_W = 32;
    localparam int LOAD_W  = 33;
    localparam int SUM_W   = 64;
    localparam int COUNT_W = 24;
    localparam int SEQ_W   = 32;
    localparam int IN_W    = 144;
    localparam int OUT_W   = 216;
    localparam int OUT_USED_W = 2 * LOAD_W + 3 * CYC_W + LAT_W + SEQ_W;
    localparam int ITER_W  = $clog2(LOAD_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] RESET_WINDOW_LENGTH = 24'd10000;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic [LOAD_W-1:0]  peak_load;
        logic [CYC_W-1:0]   peak_control;
        logic [CYC_W-1:0]   peak_scope;
        logic [LAT_W-1:0]   peak_latency;
        logic [STAMP_W-1:0] peak_time;
        logic [SEQ_W-1:0]   sequence_number;
    } snapshot_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

[design/wlp_front.sv]
`default_nettype none

module wlp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [wlp_pkg::IN_W-1:0]      s_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [wlp_pkg::COUNT_W-1:0]   cfg_wdata,
    input  wire wlp_pkg::queue_status_t        q_status,
    output logic                               push,
    output wlp_pkg::snapshot_t                 push_data
);
    import wlp_pkg::*;

    logic [COUNT_W-1:0] window_length_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [LOAD_W-1:0]  peak_load_reg;
    logic [CYC_W-1:0]   peak_control_reg;
    logic [CYC_W-1:0]   peak_scope_reg;
    logic [LAT_W-1:0]   peak_latency_reg;
    logic [STAMP_W-1:0] peak_time_reg;
    logic [SEQ_W-1:0]   seq_reg;

    logic [CYC_W-1:0]   handler;
    logic [CYC_W-1:0]   control;
    logic [CYC_W-1:0]   scope;
    logic [LAT_W-1:0]   latency;
    logic [STAMP_W-1:0] stamp;
    logic [LOAD_W-1:0]  load;
    logic               accept;
    logic               better;
    logic               done;
    logic [COUNT_W-1:0] limit;
    logic [SUM_W-1:0]   sum_next;
    logic [COUNT_W-1:0] count_next;
    logic [LOAD_W-1:0]  peak_load_next;
    logic [CYC_W-1:0]   peak_control_next;
    logic [CYC_W-1:0]   peak_scope_next;
    logic [LAT_W-1:0]   peak_latency_next;
    logic [STAMP_W-1:0] peak_time_next;
    logic [SEQ_W-1:0]   seq_next;

    assign handler = s_tdata[31:0];
    assign control = s_tdata[63:32];
    assign scope   = s_tdata[95:64];
    assign latency = s_tdata[111:96];
    assign stamp   = s_tdata[143:112] & TIME_MASK;
    assign load    = {1'b0, handler} + {{(LOAD_W - LAT_W){1'b0}}, latency};

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign better   = load > peak_load_reg;
    assign limit    = (window_length_reg == '0) ? COUNT_W'(1) : window_length_reg;

    always_comb
    begin
        sum_next          = sum_reg + {{(SUM_W - LOAD_W){1'b0}}, load};
        count_next        = count_reg + COUNT_W'(1);
        peak_load_next    = better ? load    : peak_load_reg;
        peak_control_next = better ? control : peak_control_reg;
        peak_scope_next   = better ? scope   : peak_scope_reg;
        peak_latency_next = better ? latency : peak_latency_reg;
        peak_time_next    = better ? stamp   : peak_time_reg;
        done              = count_next >= limit;
        seq_next          = seq_reg + SEQ_W'(1);
        if (seq_next == '0)
        begin
            seq_next = SEQ_W'(1);
        end
    end

    assign push                      = accept && done;
    assign push_data.sum             = sum_next;
    assign push_data.count           = count_next;
    assign push_data.peak_load       = peak_load_next;
    assign push_data.peak_control    = peak_control_next;
    assign push_data.peak_scope      = peak_scope_next;
    assign push_data.peak_latency    = peak_latency_next;
    assign push_data.peak_time       = peak_time_next;
    assign push_data.sequence_number = seq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= RESET_WINDOW_LENGTH;
            sum_reg           <= '0;
            count_reg         <= '0;
            peak_load_reg     <= '0;
            peak_control_reg  <= '0;
            peak_scope_reg    <= '0;
            peak_latency_reg  <= '0;
            peak_time_reg     <= '0;
            seq_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_length_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (done)
                begin
                    sum_reg          <= '0;
                    count_reg        <= '0;
                    peak_load_reg    <= '0;
                    peak_control_reg <= '0;
                    peak_scope_reg   <= '0;
                    peak_latency_reg <= '0;
                    peak_time_reg    <= '0;
                    seq_reg          <= seq_next;
                end
                else
                begin
                    sum_reg          <= sum_next;
                    count_reg        <= count_next;
                    peak_load_reg    <= peak_load_next;
                    peak_control_reg <= peak_control_next;
                    peak_scope_reg   <= peak_scope_next;
                    peak_latency_reg <= peak_latency_next;
                    peak_time_reg    <= peak_time_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

[design/wlp_queue.sv]
`default_nettype none

module wlp_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire wlp_pkg::snapshot_t push_data,
    input  wire logic               pop,
    output wlp_pkg::snapshot_t      head,
    output wlp_pkg::queue_status_t  status
);
    import wlp_pkg::*;

    snapshot_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  fill_reg;
    logic               do_push;
    logic               do_pop;

    assign status.full  = fill_reg == QCNT_W'(QUEUE_DEPTH);
    assign status.empty = fill_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/wlp_back.sv]
`default_nettype none

module wlp_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire wlp_pkg::snapshot_t        head,
    input  wire wlp_pkg::queue_status_t    q_status,
    output logic                           pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [wlp_pkg::OUT_W-1:0]      m_tdata
);
    import wlp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } back_state_t;

    back_state_t         state_reg;
    back_state_t         state_next;
    snapshot_t           snap_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [COUNT_W-1:0]  rem_next;
    logic [LOAD_W-1:0]   dq_reg;
    logic [LOAD_W-1:0]   dq_next;
    logic [ITER_W-1:0]   iter_reg;
    logic [ITER_W-1:0]   iter_next;
    logic [COUNT_W:0]    trial;
    logic [COUNT_W:0]    trial_diff;
    logic                fits;

    // The quotient is below 2^33, so the upper sum bits start as a partial
    // remainder that is already smaller than the divisor.
    assign trial      = {rem_reg, dq_reg[LOAD_W-1]};
    assign trial_diff = trial - {1'b0, snap_reg.count};
    assign fits       = trial >= {1'b0, snap_reg.count};
    assign pop        = (state_reg == ST_IDLE) && !q_status.empty;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        iter_next  = iter_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    rem_next   = head.sum[SUM_W-8:LOAD_W];
                    dq_next    = head.sum[LOAD_W-1:0];
                    iter_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = fits ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
                dq_next   = {dq_reg[LOAD_W-2:0], fits};
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(LOAD_W - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            snap_reg <= head;
        end
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        iter_reg <= iter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign m_tvalid = state_reg == ST_OUT;
    assign m_tdata  = {{(OUT_W - OUT_USED_W){1'b0}},
                       snap_reg.sequence_number,
                       snap_reg.peak_time,
                       snap_reg.peak_latency,
                       snap_reg.peak_scope,
                       snap_reg.peak_control,
                       snap_reg.peak_load,
                       dq_reg};

endmodule

`default_nettype wire

[design/windowed_load_profiler.sv]
`default_nettype none

// Windowed load profiler. Each input item is one profiling sample, and the block can take
// one sample in every cycle. A sample's load (handler cycles plus entry latency, 33 bits)
// goes into a window sum and a strictly greater load becomes the new window peak. When the
// sample count reaches window_length (zero counts as one), a snapshot with the average
// load, the peak fields and a nonzero window number is produced. The average comes from a
// restoring divider that yields one quotient bit per cycle. Each snapshot is popped from
// the queue into the divider and, once divided, waits on the output register until it
// is taken; the divider takes one snapshot at a time. Up to two finished windows wait in
// a queue ahead of the divider; input is held off only while that queue is full, so the
// block takes one sample per cycle unless short windows fill the queue faster than the
// divider empties it. A write of window_length applies to the samples after it and does
// not clear the window in progress.
module windowed_load_profiler (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // handler_cycles, control_part_cycles, scope_part_cycles, entry_latency, timestamp
    input  wire logic [wlp_pkg::IN_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // load_average, load_maximum, control_at_max, scope_at_max, latency_at_max,
    // time_at_max, window_number, zero fill
    output logic [wlp_pkg::OUT_W-1:0]          m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [wlp_pkg::COUNT_W-1:0]   cfg_wdata
);
    import wlp_pkg::*;

    logic          push;
    logic          pop;
    snapshot_t     push_data;
    snapshot_t     head;
    queue_status_t q_status;

    wlp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    wlp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    wlp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[design/wlp_checker.sv]
`default_nettype none

module wlp_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic [wlp_pkg::OUT_W-1:0] m_tdata
);
    import wlp_pkg::*;

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

    // The window number never takes the value zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[209:178] != '0)
    else $error("window number is zero");

    // The average load of a window cannot exceed its peak load.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[32:0] <= m_tdata[65:33])
    else $error("average above peak");

    // Results never come back to back: a taken result sends the FSM to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
    else $error("result followed too soon");

endmodule

bind windowed_load_profiler wlp_checker u_wlp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
